// File: rtl/core/rotational_anisotropy_field_4_2_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ROTATIONAL_ANISOTROPY_FIELD_4_2_DEFINES_SVH
`define ROTATIONAL_ANISOTROPY_FIELD_4_2_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off during reset
`define RAF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("raf assertion failed");

// Next-cycle implication, clocked on clk, off during reset
`define RAF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("raf assertion failed");

`else

`define RAF_ASSERT_IMP(lbl, ante, cons)
`define RAF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/raf_pkg.sv
package raf_pkg;

	// Request action codes
	typedef enum logic {
		ACT_COMPUTE = 1'b0,
		ACT_LOAD    = 1'b1
	} action_t;

	// 6/7 in Q.30
	localparam logic signed [31:0] SIX_SEVENTHS_Q30 = 32'sd920350135;

	// Input request
	typedef struct packed {
		logic               action;
		logic        [3:0]  material;
		logic signed [15:0] spin_x;
		logic signed [15:0] spin_y;
		logic signed [15:0] spin_z;
		logic signed [31:0] field_in_x;
		logic signed [31:0] field_in_y;
		logic signed [31:0] field_in_z;
		logic signed [31:0] k_value;
		logic               last_atom;
	} in_req_t;

	// Result
	typedef struct packed {
		logic signed [31:0] field_out_x;
		logic signed [31:0] field_out_y;
		logic signed [31:0] field_out_z;
		logic signed [31:0] energy;
		logic               batch_end;
	} out_rsp_t;

	// One material table entry: first axis f, second axis g (Q1.15), k (Q16.16)
	typedef struct packed {
		logic signed [15:0] f_x;
		logic signed [15:0] f_y;
		logic signed [15:0] f_z;
		logic signed [15:0] g_x;
		logic signed [15:0] g_y;
		logic signed [15:0] g_z;
		logic signed [31:0] k;
	} entry_t;

	// Sideband carried alongside the arithmetic
	typedef struct packed {
		logic               action;
		logic               last;
		logic signed [31:0] fin_x;
		logic signed [31:0] fin_y;
		logic signed [31:0] fin_z;
		entry_t             ent;
	} side_t;

	// Per-stage load enables, stage 2 through 9
	typedef struct packed {
		logic s9;
		logic s8;
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
	} pipe_en_t;

	// Saturate a 48-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [31:0] r;
		if ((&x[47:31]) || !(|x[47:31])) begin
			r = x[31:0];
		end else if (x[47]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/raf_ram.sv
module raf_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_W-1:0]    raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/raf_proj.sv
module raf_proj (
	input  logic               clk,
	input  raf_pkg::pipe_en_t  pen,
	input  raf_pkg::entry_t    ent,
	input  logic signed [15:0] spin_x,
	input  logic signed [15:0] spin_y,
	input  logic signed [15:0] spin_z,
	output logic signed [17:0] a_s3,
	output logic signed [17:0] b_s3
);

	logic signed [31:0] pfx_s2, pfy_s2, pfz_s2;
	logic signed [31:0] pgx_s2, pgy_s2, pgz_s2;
	logic signed [33:0] sum_a, sum_b;

	// Stage 2: spin times each axis component
	always_ff @(posedge clk) begin
		if (pen.s2) begin
			pfx_s2 <= 32'(spin_x) * 32'(ent.f_x);
			pfy_s2 <= 32'(spin_y) * 32'(ent.f_y);
			pfz_s2 <= 32'(spin_z) * 32'(ent.f_z);
			pgx_s2 <= 32'(spin_x) * 32'(ent.g_x);
			pgy_s2 <= 32'(spin_y) * 32'(ent.g_y);
			pgz_s2 <= 32'(spin_z) * 32'(ent.g_z);
		end
	end

	// Stage 3: dot products, Q.30 down to Q.15
	assign sum_a = 34'(pfx_s2) + 34'(pfy_s2) + 34'(pfz_s2);
	assign sum_b = 34'(pgx_s2) + 34'(pgy_s2) + 34'(pgz_s2);

	always_ff @(posedge clk) begin
		if (pen.s3) begin
			a_s3 <= 18'(sum_a >>> 15);
			b_s3 <= 18'(sum_b >>> 15);
		end
	end

endmodule

// File: rtl/core/raf_poly.sv
module raf_poly (
	input  logic               clk,
	input  raf_pkg::pipe_en_t  pen,
	input  logic signed [17:0] a_s3,
	input  logic signed [17:0] b_s3,
	input  logic signed [31:0] k_s6,
	output logic signed [43:0] cx_s7,
	output logic signed [43:0] cy_s7,
	output logic signed [46:0] ev_s7
);

	logic signed [17:0] a_s4, b_s4, a_s5, b_s5;
	logic signed [35:0] a2_s4, b2_s4, ab_full_s4;
	logic signed [37:0] six_w, px_w, py_w, pe_w;
	logic signed [22:0] px_s5, py_s5, pe_s5;
	logic signed [20:0] ab_s5;
	logic signed [40:0] m1_w, m2_w;
	logic signed [43:0] m3_w;
	logic signed [25:0] m1_s6, m2_s6;
	logic signed [28:0] m3_s6;
	logic signed [57:0] cx_w, cy_w;
	logic signed [60:0] ev_w;

	// Stage 4: squares and cross product
	always_ff @(posedge clk) begin
		if (pen.s4) begin
			a2_s4      <= 36'(a_s3) * 36'(a_s3);
			b2_s4      <= 36'(b_s3) * 36'(b_s3);
			ab_full_s4 <= 36'(a_s3) * 36'(b_s3);
			a_s4       <= a_s3;
			b_s4       <= b_s3;
		end
	end

	// Stage 5: polynomials in Q.30, taken to Q.15
	assign six_w = 38'(raf_pkg::SIX_SEVENTHS_Q30);
	assign px_w  = six_w - (38'(a2_s4) <<< 1) - 38'(a2_s4) - 38'(b2_s4);
	assign py_w  = six_w - (38'(b2_s4) <<< 1) - 38'(b2_s4) - 38'(a2_s4);
	assign pe_w  = 38'(a2_s4) + 38'(b2_s4) - six_w;

	always_ff @(posedge clk) begin
		if (pen.s5) begin
			px_s5 <= 23'(px_w >>> 15);
			py_s5 <= 23'(py_w >>> 15);
			pe_s5 <= 23'(pe_w >>> 15);
			ab_s5 <= 21'(ab_full_s4 >>> 15);
			a_s5  <= a_s4;
			b_s5  <= b_s4;
		end
	end

	// Stage 6: projection times polynomial
	assign m1_w = 41'(b_s5) * 41'(px_s5);
	assign m2_w = 41'(a_s5) * 41'(py_s5);
	assign m3_w = 44'(ab_s5) * 44'(pe_s5);

	always_ff @(posedge clk) begin
		if (pen.s6) begin
			m1_s6 <= 26'(m1_w >>> 15);
			m2_s6 <= 26'(m2_w >>> 15);
			m3_s6 <= 29'(m3_w >>> 15);
		end
	end

	// Stage 7: times 2k, folded into a shift of 14
	assign cx_w = 58'(k_s6) * 58'(m1_s6);
	assign cy_w = 58'(k_s6) * 58'(m2_s6);
	assign ev_w = 61'(k_s6) * 61'(m3_s6);

	always_ff @(posedge clk) begin
		if (pen.s7) begin
			cx_s7 <= 44'(cx_w >>> 14);
			cy_s7 <= 44'(cy_w >>> 14);
			ev_s7 <= 47'(ev_w >>> 14);
		end
	end

endmodule

// File: rtl/core/raf_apply.sv
module raf_apply (
	input  logic               clk,
	input  raf_pkg::pipe_en_t  pen,
	input  logic               enable,
	input  raf_pkg::side_t     side_s7,
	input  raf_pkg::side_t     side_s8,
	input  logic signed [43:0] cx_s7,
	input  logic signed [43:0] cy_s7,
	input  logic signed [46:0] ev_s7,
	output raf_pkg::out_rsp_t  rsp_s9
);

	logic signed [59:0] xfx_s8, xfy_s8, xfz_s8;
	logic signed [59:0] ygx_s8, ygy_s8, ygz_s8;
	logic signed [31:0] e_s8;
	logic signed [60:0] sum_x, sum_y, sum_z;
	logic signed [46:0] new_x, new_y, new_z;

	// Stage 8: field terms along each axis, energy saturation
	always_ff @(posedge clk) begin
		if (pen.s8) begin
			xfx_s8 <= 60'(cx_s7) * 60'(side_s7.ent.f_x);
			xfy_s8 <= 60'(cx_s7) * 60'(side_s7.ent.f_y);
			xfz_s8 <= 60'(cx_s7) * 60'(side_s7.ent.f_z);
			ygx_s8 <= 60'(cy_s7) * 60'(side_s7.ent.g_x);
			ygy_s8 <= 60'(cy_s7) * 60'(side_s7.ent.g_y);
			ygz_s8 <= 60'(cy_s7) * 60'(side_s7.ent.g_z);
			e_s8   <= raf_pkg::sat32(48'(ev_s7));
		end
	end

	// Stage 9: Q.31 sum to Q16.16, added to running field when enabled; loads give zeros
	assign sum_x = 61'(xfx_s8) + 61'(ygx_s8);
	assign sum_y = 61'(xfy_s8) + 61'(ygy_s8);
	assign sum_z = 61'(xfz_s8) + 61'(ygz_s8);
	assign new_x = 47'(side_s8.fin_x) + 47'(sum_x >>> 15);
	assign new_y = 47'(side_s8.fin_y) + 47'(sum_y >>> 15);
	assign new_z = 47'(side_s8.fin_z) + 47'(sum_z >>> 15);

	always_ff @(posedge clk) begin
		if (pen.s9) begin
			rsp_s9.batch_end <= side_s8.last;
			if (side_s8.action == raf_pkg::ACT_LOAD) begin
				rsp_s9.field_out_x <= '0;
				rsp_s9.field_out_y <= '0;
				rsp_s9.field_out_z <= '0;
				rsp_s9.energy      <= '0;
			end else if (enable) begin
				rsp_s9.field_out_x <= raf_pkg::sat32(48'(new_x));
				rsp_s9.field_out_y <= raf_pkg::sat32(48'(new_y));
				rsp_s9.field_out_z <= raf_pkg::sat32(48'(new_z));
				rsp_s9.energy      <= e_s8;
			end else begin
				rsp_s9.field_out_x <= side_s8.fin_x;
				rsp_s9.field_out_y <= side_s8.fin_y;
				rsp_s9.field_out_z <= side_s8.fin_z;
				rsp_s9.energy      <= e_s8;
			end
		end
	end

endmodule

// File: rtl/core/rotational_anisotropy_field_4_2.sv
// Rotational anisotropy field kernel, one atom per request.
// Input channel in_valid/in_stall/in_req: a load request writes the material
// table entry (first axis from spin, second axis from the low 16 bits of the
// field inputs, k from k_value); a compute request projects the spin on the
// entry's axes and, when enabled, adds the anisotropy field to the running field.
// Output channel out_valid/out_stall/out_rsp: one result per request, in order;
// load requests return zero field and energy with batch_end echoed.
// cfg_wr_en/cfg_wr_data write the enable bit; write it only while idle.
// Pipeline: one table read stage and eight arithmetic stages, each with at most
// one multiply level. Throughput is one request per cycle while the output is not
// stalled; the table is read and written on the accept cycle, so a compute right
// after a load of the same entry sees the new data.
// A stalled output holds its result; earlier stages keep filling empty slots,
// and in_stall rises only once the first stage holds a request that cannot move.
// Reset clears the stage valid bits and the enable bit. The material table has
// no reset; computing on an entry never loaded gives undefined results.
`include "rotational_anisotropy_field_4_2_defines.svh"

module rotational_anisotropy_field_4_2 #(
	parameter int NUM_MATERIALS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  raf_pkg::in_req_t   in_req,
	output logic               out_valid,
	input  logic               out_stall,
	output raf_pkg::out_rsp_t  out_rsp,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data
);

	localparam int ADDR_W = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;

	logic [9:1]             vld_q;
	logic [9:1]             load;
	raf_pkg::pipe_en_t      pen;
	logic                   enable_q;
	logic                   accept, in_range;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_addr;
	raf_pkg::entry_t        wr_ent;
	logic [$bits(raf_pkg::entry_t)-1:0] ram_rdata;
	raf_pkg::in_req_t       req_s1;
	logic                   zero_s1;
	raf_pkg::entry_t        ent_s1;
	raf_pkg::side_t         side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic signed [17:0]     a_s3, b_s3;
	logic signed [43:0]     cx_s7, cy_s7;
	logic signed [46:0]     ev_s7;

	// Stage load chain: a stage takes new data when empty or when it moves on
	always_comb begin
		load[9] = !vld_q[9] || !out_stall;
		for (int i = 8; i >= 1; i--) begin
			load[i] = !vld_q[i] || load[i+1];
		end
	end

	assign pen = '{s9: load[9], s8: load[8], s7: load[7], s6: load[6],
		s5: load[5], s4: load[4], s3: load[3], s2: load[2]};

	assign in_stall  = !load[1];
	assign accept    = in_valid && load[1];
	assign out_valid = vld_q[9];

	// Valid bits and enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			enable_q <= 1'b0;
		end else begin
			if (load[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= 9; i++) begin
				if (load[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
		end
	end

	// Material table access on the accept cycle
	assign in_range = 32'(in_req.material) < NUM_MATERIALS;
	assign ram_addr = ADDR_W'(in_req.material);
	assign ram_we   = accept && (in_req.action == raf_pkg::ACT_LOAD) && in_range;
	assign wr_ent   = '{f_x: in_req.spin_x, f_y: in_req.spin_y, f_z: in_req.spin_z,
		g_x: in_req.field_in_x[15:0], g_y: in_req.field_in_y[15:0],
		g_z: in_req.field_in_z[15:0], k: in_req.k_value};

	raf_ram #(
		.WIDTH ($bits(raf_pkg::entry_t)),
		.DEPTH (NUM_MATERIALS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (wr_ent),
		.re    (load[1]),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// Stage 1 request register; out-of-range materials read as an empty entry
	always_ff @(posedge clk) begin
		if (load[1]) begin
			req_s1  <= in_req;
			zero_s1 <= !in_range;
		end
	end

	assign ent_s1 = zero_s1 ? '0 : raf_pkg::entry_t'(ram_rdata);

	// Sideband pipeline
	always_ff @(posedge clk) begin
		if (load[2]) begin
			side_s2 <= '{action: req_s1.action, last: req_s1.last_atom,
				fin_x: req_s1.field_in_x, fin_y: req_s1.field_in_y,
				fin_z: req_s1.field_in_z, ent: ent_s1};
		end
		if (load[3]) side_s3 <= side_s2;
		if (load[4]) side_s4 <= side_s3;
		if (load[5]) side_s5 <= side_s4;
		if (load[6]) side_s6 <= side_s5;
		if (load[7]) side_s7 <= side_s6;
		if (load[8]) side_s8 <= side_s7;
	end

	raf_proj u_proj (
		.clk    (clk),
		.pen    (pen),
		.ent    (ent_s1),
		.spin_x (req_s1.spin_x),
		.spin_y (req_s1.spin_y),
		.spin_z (req_s1.spin_z),
		.a_s3   (a_s3),
		.b_s3   (b_s3)
	);

	raf_poly u_poly (
		.clk   (clk),
		.pen   (pen),
		.a_s3  (a_s3),
		.b_s3  (b_s3),
		.k_s6  (side_s6.ent.k),
		.cx_s7 (cx_s7),
		.cy_s7 (cy_s7),
		.ev_s7 (ev_s7)
	);

	raf_apply u_apply (
		.clk     (clk),
		.pen     (pen),
		.enable  (enable_q),
		.side_s7 (side_s7),
		.side_s8 (side_s8),
		.cx_s7   (cx_s7),
		.cy_s7   (cy_s7),
		.ev_s7   (ev_s7),
		.rsp_s9  (out_rsp)
	);

	// Checks
	`RAF_ASSERT_IMP(a_full_stall, (&vld_q) && out_stall, in_stall)
	`RAF_ASSERT_IMP(a_stall_has_item, in_stall, vld_q[1])
	`RAF_ASSERT_IMP(a_we_on_load, ram_we, in_valid && !in_stall && (in_req.action == raf_pkg::ACT_LOAD))
	`RAF_ASSERT_NXT(a_accept_fills, in_valid && !in_stall, vld_q[1])

endmodule

// File: dv/rotational_anisotropy_field_4_2_test.sv
module rotational_anisotropy_field_4_2_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 170;

	// Directed stimulus row: enable setting, request, optional hand-written result
	typedef struct {
		bit                 en;
		raf_pkg::in_req_t   req;
		bit                 typed;
		raf_pkg::out_rsp_t  rsp;
	} dir_row_t;

	// Idling profile and enable setting of one random phase
	typedef struct {
		int gap;
		int stall;
		bit en;
	} phase_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	raf_pkg::in_req_t  in_req = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	raf_pkg::out_rsp_t out_rsp;
	logic              cfg_wr_en = 1'b0;
	logic              cfg_wr_data = 1'b0;

	// Predictor state: material table, written flags, enable register
	raf_pkg::entry_t   mat_tbl [16];
	bit                mat_loaded [16];
	bit                en_reg = 1'b0;

	raf_pkg::out_rsp_t pending_fields [$];
	raf_pkg::out_rsp_t want_rsp;
	dir_row_t          script [$];
	phase_t            phases [6];

	int          gap_pct = 0;
	int          stall_pct = 0;
	int          n_fail = 0;
	int unsigned cycles = 0;

	rotational_anisotropy_field_4_2 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_req     (in_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_rsp    (out_rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Anisotropy field and energy for one request; loads update the table
	function automatic raf_pkg::out_rsp_t anisotropy_result(raf_pkg::in_req_t r);
		raf_pkg::entry_t   e;
		raf_pkg::out_rsp_t o;
		longint   sx, sy, sz, kk, a, b, a2, b2, px, py, cx, cy, ab, pe, v;
		longint   fa [3];
		longint   ga [3];
		longint   fin [3];
		longint   fo [3];
		o = '0;
		o.batch_end = r.last_atom;
		if (r.action == raf_pkg::ACT_LOAD) begin
			e.f_x = r.spin_x;
			e.f_y = r.spin_y;
			e.f_z = r.spin_z;
			e.g_x = r.field_in_x[15:0];
			e.g_y = r.field_in_y[15:0];
			e.g_z = r.field_in_z[15:0];
			e.k   = r.k_value;
			mat_tbl[r.material] = e;
			mat_loaded[r.material] = 1'b1;
			return o;
		end
		e = mat_tbl[r.material];
		sx = $signed(r.spin_x);
		sy = $signed(r.spin_y);
		sz = $signed(r.spin_z);
		fa[0] = $signed(e.f_x);
		fa[1] = $signed(e.f_y);
		fa[2] = $signed(e.f_z);
		ga[0] = $signed(e.g_x);
		ga[1] = $signed(e.g_y);
		ga[2] = $signed(e.g_z);
		kk = $signed(e.k);
		fin[0] = $signed(r.field_in_x);
		fin[1] = $signed(r.field_in_y);
		fin[2] = $signed(r.field_in_z);

		// projections onto both axes, Q.15
		a = (sx * fa[0] + sy * fa[1] + sz * fa[2]) >>> 15;
		b = (sx * ga[0] + sy * ga[1] + sz * ga[2]) >>> 15;
		a2 = a * a;
		b2 = b * b;

		// field magnitudes along each axis, Q16.16
		px = (raf_pkg::SIX_SEVENTHS_Q30 - 3 * a2 - b2) >>> 15;
		py = (raf_pkg::SIX_SEVENTHS_Q30 - 3 * b2 - a2) >>> 15;
		cx = (2 * kk * ((b * px) >>> 15)) >>> 15;
		cy = (2 * kk * ((a * py) >>> 15)) >>> 15;
		for (int i = 0; i < 3; i++) begin
			v = fin[i];
			if (en_reg)
				v = clamp32(v + ((cx * fa[i] + cy * ga[i]) >>> 15));
			fo[i] = v;
		end
		o.field_out_x = fo[0][31:0];
		o.field_out_y = fo[1][31:0];
		o.field_out_z = fo[2][31:0];

		// energy is computed whatever the enable
		ab = (a * b) >>> 15;
		pe = (a2 + b2 - raf_pkg::SIX_SEVENTHS_Q30) >>> 15;
		v = clamp32((2 * kk * ((ab * pe) >>> 15)) >>> 15);
		o.energy = v[31:0];
		return o;
	endfunction

	function automatic raf_pkg::in_req_t mk_req(logic act, logic [3:0] mat,
			logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
			logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
			logic [31:0] k, logic last);
		raf_pkg::in_req_t r;
		r.action = act;
		r.material = mat;
		r.spin_x = sx;
		r.spin_y = sy;
		r.spin_z = sz;
		r.field_in_x = fx;
		r.field_in_y = fy;
		r.field_in_z = fz;
		r.k_value = k;
		r.last_atom = last;
		return r;
	endfunction

	function automatic raf_pkg::out_rsp_t mk_rsp(logic [31:0] fx, logic [31:0] fy,
			logic [31:0] fz, logic [31:0] en_val, logic last);
		raf_pkg::out_rsp_t o;
		o.field_out_x = fx;
		o.field_out_y = fy;
		o.field_out_z = fz;
		o.energy = en_val;
		o.batch_end = last;
		return o;
	endfunction

	task automatic add_row(bit en, raf_pkg::in_req_t req, bit typed, raf_pkg::out_rsp_t rsp);
		dir_row_t row;
		row.en = en;
		row.req = req;
		row.typed = typed;
		row.rsp = rsp;
		script.push_back(row);
	endtask

	// Q1.15 component: extremes, zero, small or anything
	function automatic logic [15:0] rand_q15();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(2047)) - 16'd1024;
			default: return 16'($urandom);
		endcase
	endfunction

	// Q16.16 running field
	function automatic logic [31:0] rand_field();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3, 4: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	// Q16.16 anisotropy constant, mostly moderate
	function automatic logic [31:0] rand_k();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3, 4: return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	// Random request; computes only touch entries already loaded
	function automatic raf_pkg::in_req_t rand_request();
		raf_pkg::in_req_t r;
		int      m;
		r.action = ($urandom_range(4) == 0) ? raf_pkg::ACT_LOAD : raf_pkg::ACT_COMPUTE;
		r.last_atom = ($urandom_range(7) == 0);
		r.spin_x = rand_q15();
		r.spin_y = rand_q15();
		r.spin_z = rand_q15();
		r.k_value = rand_k();
		if (r.action == raf_pkg::ACT_LOAD) begin
			m = $urandom_range(15);
			r.field_in_x = {16'($urandom), rand_q15()};
			r.field_in_y = {16'($urandom), rand_q15()};
			r.field_in_z = {16'($urandom), rand_q15()};
		end else begin
			do
				m = $urandom_range(15);
			while (!mat_loaded[m]);
			r.field_in_x = rand_field();
			r.field_in_y = rand_field();
			r.field_in_z = rand_field();
		end
		r.material = m[3:0];
		return r;
	endfunction

	// Offer one request and record its expected result at acceptance
	task automatic send(raf_pkg::in_req_t r, bit typed, raf_pkg::out_rsp_t rsp);
		raf_pkg::out_rsp_t o;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do
			@(posedge clk);
		while (in_stall);
		o = anisotropy_result(r);
		pending_fields.push_back(typed ? rsp : o);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_fields.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_enable(bit v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		en_reg = v;
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
			n_fail++;
		end
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fields.size() == 0) begin
				$error("result with no request outstanding");
				n_fail++;
			end else begin
				want_rsp = pending_fields.pop_front();
				check_field("field_out_x", want_rsp.field_out_x, out_rsp.field_out_x);
				check_field("field_out_y", want_rsp.field_out_y, out_rsp.field_out_y);
				check_field("field_out_z", want_rsp.field_out_z, out_rsp.field_out_z);
				check_field("energy", want_rsp.energy, out_rsp.energy);
				check_field("batch_end", 32'(want_rsp.batch_end), 32'(out_rsp.batch_end));
			end
		end
	end

	initial begin
		foreach (mat_tbl[i]) begin
			mat_tbl[i] = '0;
			mat_loaded[i] = 1'b0;
		end
		phases[0] = '{gap: 0, stall: 0, en: 1'b1};
		phases[1] = '{gap: 87, stall: 0, en: 1'b1};
		phases[2] = '{gap: 0, stall: 87, en: 1'b0};
		phases[3] = '{gap: 11, stall: 11, en: 1'b1};
		phases[4] = '{gap: 87, stall: 0, en: 1'b0};
		phases[5] = '{gap: 0, stall: 87, en: 1'b1};

		// enable clear (reset value): loads return zeros, field passes through
		add_row(0, mk_req(raf_pkg::ACT_LOAD, 0, 32767, 0, 0, 0, 32767, 0, 32'h0001_0000, 0),
			1, mk_rsp(0, 0, 0, 0, 0));
		add_row(0, mk_req(raf_pkg::ACT_LOAD, 15, -32768, 0, 0, 32'h1234_0000,
			32'hffff_0000, 32'h5a5a_8000, 32'h7fff_ffff, 1), 1, mk_rsp(0, 0, 0, 0, 1));
		add_row(0, mk_req(raf_pkg::ACT_LOAD, 1, 0, 0, 32767, 32767, 0, 0, 0, 0),
			1, mk_rsp(0, 0, 0, 0, 0));
		add_row(0, mk_req(raf_pkg::ACT_COMPUTE, 0, 23170, 23170, 0, 32'h7fff_ffff,
			32'h8000_0000, 0, 0, 0), 0, '0);
		add_row(0, mk_req(raf_pkg::ACT_COMPUTE, 1, 1000, -2000, 3000, 123, -456, 789,
			32'hdead_beef, 1), 1, mk_rsp(123, -456, 789, 0, 1));
		add_row(0, mk_req(raf_pkg::ACT_COMPUTE, 15, -32768, -32768, -32768, 32'h7fff_ffff,
			32'h8000_0000, 32'hffff_ffff, 0, 0), 0, '0);

		// enable set; entry 1 has zero k and adds nothing, entry 0 has nonzero k
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 1, -32768, -32768, -32768, 32'h7fff_ffff,
			32'h8000_0000, 32'hffff_ffff, 0, 1),
			1, mk_rsp(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 1));
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 0, 32767, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 0, 23170, 23170, 0, 1000, 2000, 3000,
			0, 0), 0, '0);

		// saturation at both ends
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 15, -32768, -32768, -32768, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 0, 0), 0, '0);
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 15, 32767, 32767, 32767, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 0, 1), 0, '0);
		add_row(1, mk_req(raf_pkg::ACT_LOAD, 2, -32768, -32768, -32768, 32'hffff_8000,
			32'hffff_8000, 32'hffff_8000, 32'h8000_0000, 0), 1, mk_rsp(0, 0, 0, 0, 0));
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 2, -32768, -32768, -32768, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 0, 0), 0, '0);
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 2, 32767, 32767, 32767, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 0, 0), 0, '0);

		// zero spin: no projection, no field, no energy
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 2, 0, 0, 0, 5, -5, 32'h7fff_ffff, 0, 1),
			1, mk_rsp(5, -5, 32'h7fff_ffff, 0, 1));

		// reload then compute right behind it
		add_row(1, mk_req(raf_pkg::ACT_LOAD, 0, 0, 32767, 0, 0, 0, 32767, 32'h0003_0000, 0),
			1, mk_rsp(0, 0, 0, 0, 0));
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 0, 0, 23170, -23170, 0, 0, 0, 0, 0), 0, '0);
		add_row(1, mk_req(raf_pkg::ACT_COMPUTE, 0, 0, -32768, 32767, -100000, 100000, 0,
			0, 1), 0, '0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (script[i]) begin
			if (script[i].en != en_reg) begin
				quiesce();
				set_enable(script[i].en);
			end
			send(script[i].req, script[i].typed, script[i].rsp);
		end

		// random phases, each with its own idling profile and enable
		foreach (phases[p]) begin
			quiesce();
			gap_pct = phases[p].gap;
			stall_pct = phases[p].stall;
			set_enable(phases[p].en);
			repeat (ITEMS_PER_PHASE)
				send(rand_request(), 0, '0);
		end

		quiesce();
		repeat (20) @(posedge clk);
		if (n_fail == 0 && pending_fields.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: rotational_anisotropy_field_4_2.f
+incdir+rtl/core
rtl/core/raf_pkg.sv
rtl/core/raf_ram.sv
rtl/core/raf_proj.sv
rtl/core/raf_poly.sv
rtl/core/raf_apply.sv
rtl/core/rotational_anisotropy_field_4_2.sv
dv/rotational_anisotropy_field_4_2_test.sv
